/* src/dtb_pkg.sv */
// ----------------------------------------------------------------------------
// dtb_pkg: descriptor table builder package
// Types, constants and the control store shared by the table builder.
// ----------------------------------------------------------------------------
package dtb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [23:0] LIMIT_BYTES = 24'hFF0000;
  localparam logic [16:0] BOUNDARY    = 17'h10000;
  localparam logic [15:0] HALF_CHUNK  = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] buffer_address;
    logic [23:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [31:0] entry_address;
    logic [15:0] entry_bytes;
    logic        last;
    status_t     status;
  } desc_t;

  // Microprogram steps
  typedef enum logic [1:0] {
    STEP_ACCEPT = 2'd0,
    STEP_CHECK  = 2'd1,
    STEP_ENTRY  = 2'd2
  } step_t;

  typedef enum logic {
    SEL_CHECK = 1'b0,
    SEL_ENTRY = 1'b1
  } emit_sel_t;

  typedef enum logic {
    COND_ALWAYS = 1'b0,
    COND_DONE   = 1'b1
  } cond_t;

  // One control word per step
  typedef struct packed {
    logic      take_req;
    logic      emit;
    emit_sel_t sel;
    cond_t     cond;
    step_t     jump_true;
    step_t     jump_false;
  } ctl_t;

  function automatic ctl_t ucode_rom(input step_t step);
    ctl_t c;
    unique case (step)
      STEP_ACCEPT: c = '{take_req: 1'b1, emit: 1'b0, sel: SEL_CHECK, cond: COND_ALWAYS,
                         jump_true: STEP_CHECK, jump_false: STEP_CHECK};
      STEP_CHECK:  c = '{take_req: 1'b0, emit: 1'b1, sel: SEL_CHECK, cond: COND_DONE,
                         jump_true: STEP_ACCEPT, jump_false: STEP_ENTRY};
      STEP_ENTRY:  c = '{take_req: 1'b0, emit: 1'b1, sel: SEL_ENTRY, cond: COND_DONE,
                         jump_true: STEP_ACCEPT, jump_false: STEP_ENTRY};
      default:     c = '{take_req: 1'b0, emit: 1'b0, sel: SEL_CHECK, cond: COND_ALWAYS,
                         jump_true: STEP_ACCEPT, jump_false: STEP_ACCEPT};
    endcase
    return c;
  endfunction

endpackage

/* src/dma_descriptor_table_builder.sv */
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder: scatter-gather descriptor list generator
// Splits one transfer request into descriptor entries that never cross a
// 64 KiB boundary, with error and end-of-table marking.
// ----------------------------------------------------------------------------
// Sequence: the accept step takes a request beat; the check step then
// registers a too-long or empty result, or passes to the entry step, which
// registers the entry beats (up to MAX_ENTRIES, then an overflow beat).
// Throughput: the microprogram emits one descriptor beat per cycle through a
// single output register, and waits while that register is held; a new
// request is taken only after the last beat of the one before.
// Reset: synchronous; clears the step counter and the output valid flag, and
// holds req_ready low while asserted.
module dma_descriptor_table_builder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dtb_pkg::req_t  req,
  output logic           desc_valid,
  input  logic           desc_ready,
  output dtb_pkg::desc_t desc
);

  // Sequencer state
  dtb_pkg::step_t step, step_next;
  dtb_pkg::ctl_t  ctl;

  // Datapath registers: running address, bytes left, entries emitted
  logic [31:0]             addr;
  logic [23:0]             left;
  logic [dtb_pkg::CNT_W-1:0] n;

  // Output register
  dtb_pkg::desc_t desc_next;
  logic           slot_free;

  // Combinational datapath
  logic [16:0] room;
  logic [16:0] chunk_raw;
  logic [15:0] chunk;
  logic        is_last;
  logic        overflow;
  logic        too_long;
  logic        empty;
  logic        err;
  logic        need_emit;
  logic        fire;
  logic        done;

  // Fetch the control word for the current step
  assign ctl = dtb_pkg::ucode_rom(step);

  // Room up to the next 64 KiB boundary and the chunk for this entry
  assign room      = dtb_pkg::BOUNDARY - {1'b0, addr[15:0]};
  assign chunk_raw = (left < {7'd0, room}) ? left[16:0] : room;
  // Split a full aligned 64 KiB region; the second half follows on its own
  assign chunk     = (chunk_raw == dtb_pkg::BOUNDARY) ? dtb_pkg::HALF_CHUNK
                                                      : chunk_raw[15:0];
  assign is_last   = (left == {8'd0, chunk});
  assign overflow  = (n == dtb_pkg::CNT_W'(dtb_pkg::MAX_ENTRIES));

  assign too_long  = (left > dtb_pkg::LIMIT_BYTES);
  assign empty     = (left == 24'd0);
  assign err       = too_long || empty;

  // The output register is free when empty or being drained this cycle
  assign slot_free = !desc_valid || desc_ready;
  // Take no request beat while reset is held
  assign req_ready = ctl.take_req && !rst;

  always_comb begin
    need_emit = 1'b0;
    desc_next = '{entry_address: 32'd0, entry_bytes: 16'd0, last: 1'b1,
                  status: dtb_pkg::ST_OK};
    done      = 1'b0;
    unique case (ctl.sel)
      dtb_pkg::SEL_CHECK: begin
        need_emit = ctl.emit && err;
        done      = err;
        desc_next.status = too_long ? dtb_pkg::ST_TOO_LONG : dtb_pkg::ST_EMPTY;
      end
      dtb_pkg::SEL_ENTRY: begin
        need_emit = ctl.emit;
        done      = overflow || is_last;
        if (overflow) begin
          desc_next.status = dtb_pkg::ST_OVERFLOW;
        end else begin
          desc_next.entry_address = addr;
          desc_next.entry_bytes   = chunk;
          desc_next.last          = is_last;
        end
      end
      default: ;
    endcase

    // Advance when the step's own event happens: a request beat, a free slot, or at once when nothing is emitted
    if (ctl.take_req) begin
      fire = req_valid;
    end else if (need_emit) begin
      fire = slot_free;
    end else begin
      fire = 1'b1;
    end

    step_next = step;
    if (fire) begin
      unique case (ctl.cond)
        dtb_pkg::COND_ALWAYS: step_next = ctl.jump_true;
        dtb_pkg::COND_DONE:   step_next = done ? ctl.jump_true : ctl.jump_false;
        default:              step_next = ctl.jump_true;
      endcase
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dtb_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  // Datapath: load on a request beat, advance on each ok entry beat
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      addr <= req.buffer_address;
      left <= req.byte_count;
      n    <= '0;
    end else if (fire && ctl.emit && ctl.sel == dtb_pkg::SEL_ENTRY && !overflow) begin
      addr <= addr + {16'd0, chunk};
      left <= left - {8'd0, chunk};
      n    <= n + dtb_pkg::CNT_W'(1);
    end
  end

  // Output register: hold until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (need_emit && fire) begin
      desc_valid <= 1'b1;
    end else if (desc_ready) begin
      desc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (need_emit && fire) begin
      desc <= desc_next;
    end
  end

endmodule
